// File: rtl/tkpq_pkg.sv
// Shared types, widths and codes for the two-key sorted priority queue.
`default_nettype none

package tkpq_pkg;

  // Field widths of one request and one response.
  localparam int unsigned ID_W     = 16;
  localparam int unsigned EXP_W    = 6;
  localparam int unsigned SCORE_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 6;

  // Configuration defaults.
  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam logic [EXP_W-1:0] THRESHOLD_RESET = 6'd3;

  // Register map.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_THRESHOLD = 1'b0;

  // Request modes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // One stored entry.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               degree;
    logic [EXP_W-1:0]   experience;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/tkpq_if.sv
// Request and response channel interfaces of the priority queue.
`default_nettype none

interface tkpq_req_if;
  import tkpq_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [ID_W-1:0]    candidate_id;
  logic               has_degree;
  logic [EXP_W-1:0]   years_experience;
  logic [SCORE_W-1:0] score;

  modport source (output valid, mode, candidate_id, has_degree, years_experience, score,
                  input ready);
  modport sink (input valid, mode, candidate_id, has_degree, years_experience, score,
                output ready);
endinterface

interface tkpq_rsp_if;
  import tkpq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_id;
  logic                out_degree;
  logic [EXP_W-1:0]    out_experience;
  logic [SCORE_W-1:0]  out_score;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_id, out_degree, out_experience, out_score,
                  occupancy, input ready);
  modport sink (input valid, status, out_id, out_degree, out_experience, out_score,
                occupancy, output ready);
endinterface

`default_nettype wire

// File: rtl/tkpq_ctrl.sv
// Controller state machine: sequences capture, execute and response handoff.
`default_nettype none

module tkpq_ctrl
  import tkpq_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd
);

  ctrl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: take a request while idle, execute once the response register can be loaded.
  always_comb begin
    in_ready    = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
      end
      S_EXEC: begin
        cmd.exec = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.capture = in_valid && in_ready;
  end

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tkpq_dp.sv
// Datapath: sorted array of compare-and-shift cells, entry count and response register.
`default_nettype none

module tkpq_dp
  import tkpq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cmd_t                cmd,
  input  wire  [EXP_W-1:0]    threshold,
  input  wire                 mode,
  input  wire  [ID_W-1:0]     candidate_id,
  input  wire                 has_degree,
  input  wire  [EXP_W-1:0]    years_experience,
  input  wire  [SCORE_W-1:0]  score,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     out_id,
  output logic                out_degree,
  output logic [EXP_W-1:0]    out_experience,
  output logic [SCORE_W-1:0]  out_score,
  output logic [OCC_W-1:0]    occupancy
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Criterion: degree set and experience strictly above the threshold.
  function automatic logic meets(input entry_t e, input logic [EXP_W-1:0] thr);
    meets = e.degree && (e.experience > thr);
  endfunction

  // a strictly outranks b.
  function automatic logic outranks(input entry_t a, input entry_t b,
                                    input logic [EXP_W-1:0] thr);
    logic ma;
    logic mb;
    ma = meets(a, thr);
    mb = meets(b, thr);
    outranks = (ma != mb) ? ma : (a.score > b.score);
  endfunction

  logic             item_mode;
  entry_t           item;
  entry_t           slots [DEPTH];
  entry_t           cell_ins [DEPTH];
  entry_t           cell_pop [DEPTH];
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] hit_before;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             empty;
  logic             do_ins;
  logic             do_pop;

  // Captured request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode        <= mode;
      item.id          <= candidate_id;
      item.degree      <= has_degree;
      item.experience  <= years_experience;
      item.score       <= score;
    end
  end

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_ins = cmd.exec && (item_mode == MODE_INSERT) && !full;
  assign do_pop = cmd.exec && (item_mode == MODE_POP) && !empty;

  // Per-cell compare; unused cells count as the tail insertion point.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign hit[i] = !(CNT_W'(i) < count) || outranks(item, slots[i], threshold);

    if (i == 0) begin : g_head
      assign hit_before[i] = 1'b0;
      assign cell_ins[i]   = hit[i] ? item : slots[i];
    end else begin : g_body
      assign hit_before[i] = |hit[i-1:0];
      assign cell_ins[i]   = hit_before[i] ? slots[i-1] : (hit[i] ? item : slots[i]);
    end

    if (i == DEPTH - 1) begin : g_tail
      assign cell_pop[i] = slots[i];
    end else begin : g_mid
      assign cell_pop[i] = slots[i+1];
    end
  end

  // Cell array update.
  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      if (do_ins) begin
        slots[j] <= cell_ins[j];
      end else if (do_pop) begin
        slots[j] <= cell_pop[j];
      end
    end
  end

  // Entry count.
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Response register, loaded on execute.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_id         <= '0;
      out_degree     <= 1'b0;
      out_experience <= '0;
      out_score      <= '0;
      occupancy      <= OCC_W'(count_next);
      if (item_mode == MODE_INSERT) begin
        status <= full ? ST_FULL : ST_INSERTED;
      end else if (empty) begin
        status <= ST_EMPTY;
      end else begin
        status         <= ST_POPPED;
        out_id         <= slots[0].id;
        out_degree     <= slots[0].degree;
        out_experience <= slots[0].experience;
        out_score      <= slots[0].score;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/two_key_sorted_priority_queue_core.sv
// Top level of the two-key sorted priority queue: register port, controller and datapath.
//
//   Channel  Direction  Handshake        Payload
//   req      in         valid / ready    mode, candidate_id, has_degree, years_experience, score
//   rsp      out        valid / ready    status, out_id, out_degree, out_experience, out_score,
//                                        occupancy
//   apb      in         psel / penable   experience_threshold at address 0
//
// Each request is first captured and then run through the compare-and-shift cell
// array, which inserts or pops the whole array in one step.
// The execute cycle waits while the response register still holds an untaken response.
// Reset clears the entry count, the controller and the response valid flag, and sets
// the threshold to 3; the cell contents are not cleared and need no clearing pass.
`default_nettype none

module two_key_sorted_priority_queue_core
  import tkpq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire                    clk,
  input  wire                    rst,
  tkpq_req_if.sink               req,
  tkpq_rsp_if.source             rsp,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [APB_ADDR_W-1:0]  paddr,
  input  wire  [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [EXP_W-1:0] threshold;
  cmd_t             cmd;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      threshold <= pwdata[EXP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_THRESHOLD) begin
      prdata = APB_DATA_W'(threshold);
    end
  end

  // Controller.
  tkpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Datapath.
  tkpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .threshold        (threshold),
    .mode             (req.mode),
    .candidate_id     (req.candidate_id),
    .has_degree       (req.has_degree),
    .years_experience (req.years_experience),
    .score            (req.score),
    .status           (rsp.status),
    .out_id           (rsp.out_id),
    .out_degree       (rsp.out_degree),
    .out_experience   (rsp.out_experience),
    .out_score        (rsp.out_score),
    .occupancy        (rsp.occupancy)
  );

`ifndef ASSERT_OFF
  // A captured request blocks the next one until it has executed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in flight");

  // An empty response reports an empty queue.
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_EMPTY)) |-> (rsp.occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // Only a pop returns entry fields.
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != ST_POPPED)) |->
      (rsp.out_id == '0) && !rsp.out_degree && (rsp.out_experience == '0) &&
      (rsp.out_score == '0))
    else $error("entry fields set on a non-pop response");
`endif

endmodule

`default_nettype wire
